// ===== design/ped_pkg.sv =====
// shared types, constants and phase codes of the polyphonic envelope generator
package ped_pkg;

   localparam int VOICES_DEFAULT = 16;
   localparam int COUNT_WIDTH_DEFAULT = 20;

   // phase codes
   localparam logic [2:0] PH_IDLE    = 3'd0;
   localparam logic [2:0] PH_DELAY   = 3'd1;
   localparam logic [2:0] PH_ATTACK  = 3'd2;
   localparam logic [2:0] PH_HOLD    = 3'd3;
   localparam logic [2:0] PH_DECAY   = 3'd4;
   localparam logic [2:0] PH_SUSTAIN = 3'd5;
   localparam logic [2:0] PH_RELEASE = 3'd6;

   // curve codes
   localparam logic [1:0] CURVE_LIN = 2'd0;
   localparam logic [1:0] CURVE_LOG = 2'd1;
   localparam logic [1:0] CURVE_EXP = 2'd2;

   // register indexes
   localparam logic [2:0] REG_DELAY   = 3'd0;
   localparam logic [2:0] REG_HOLD    = 3'd1;
   localparam logic [2:0] REG_ATTACK  = 3'd2;
   localparam logic [2:0] REG_DECAY   = 3'd3;
   localparam logic [2:0] REG_SUSTAIN = 3'd4;
   localparam logic [2:0] REG_RELEASE = 3'd5;
   localparam logic [2:0] REG_CURVES  = 3'd6;

   // q2.30 constants, CV_MAX in q2.24
   localparam logic signed [35:0] ONE_Q30 = 36'sd1073741824;
   localparam logic signed [35:0] K_1P4   = 36'sd1503238554;
   localparam logic signed [35:0] K_0P9   = 36'sd966367642;
   localparam logic signed [35:0] K_1P1   = 36'sd1181116006;
   localparam logic signed [35:0] K_2P2   = 36'sd2362232013;
   localparam logic signed [35:0] K_0P1   = 36'sd107374182;
   localparam logic signed [35:0] K_0P01  = 36'sd10737418;
   localparam logic signed [35:0] LVL_MAX = 36'sd2147483647;
   localparam logic [26:0] CV_MAX = 27'd33554432;

   typedef struct packed {
      logic accept;
      logic load;
      logic mul1;
      logic mul2;
      logic upd;
      logic mulcv;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

   function automatic logic [30:0] cap_one(input logic [30:0] v);
      cap_one = (v > 31'd1073741824) ? 31'd1073741824 : v;
   endfunction

endpackage

// ===== design/ped_ctrl.sv =====
// envelope sequencer: steps one word through load, two multiplies, update, gain multiply, output
module ped_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  ped_pkg::status_type  status,
   output ped_pkg::cmd_type     cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_LOAD  = 3'd1;
   localparam logic [2:0] ST_MUL1  = 3'd2;
   localparam logic [2:0] ST_MUL2  = 3'd3;
   localparam logic [2:0] ST_UPD   = 3'd4;
   localparam logic [2:0] ST_MULCV = 3'd5;
   localparam logic [2:0] ST_OUT   = 3'd6;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = ST_UPD;
         end
         ST_UPD: begin
            cmd.upd = 1'b1;
            state_in = ST_MULCV;
         end
         ST_MULCV: begin
            cmd.mulcv = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

// ===== design/ped_datapath.sv =====
// datapath: registers, voice state memory, shared multiplier and output register
module ped_datapath #(
   parameter int VOICES      = ped_pkg::VOICES_DEFAULT,
   parameter int COUNT_WIDTH = ped_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ped_pkg::cmd_type     cmd,
   output ped_pkg::status_type  status,
   input  logic                 csr_write_enable,
   input  logic [2:0]           csr_index,
   input  logic [30:0]          csr_data,
   input  logic [3:0]           req_voice,
   input  logic signed [15:0]   req_gate_sample,
   input  logic [15:0]          req_gain_sample,
   input  logic                 req_gain_present,
   input  logic                 req_block_end,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [3:0]           rsp_out_voice,
   output logic [25:0]          rsp_cv_out,
   output logic                 rsp_out_block_end
);

   localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int CW = COUNT_WIDTH;
   localparam int WW = 3 + 32 + CW;

   // configuration
   logic [19:0] delay_ff, hold_ff;
   logic [30:0] attack_ff, decay_ff, sustain_ff, release_ff;
   logic [5:0]  curves_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff   <= 20'd5;
         hold_ff    <= 20'd5;
         attack_ff  <= 31'd44739;
         decay_ff   <= 31'd74565;
         sustain_ff <= 31'd536870912;
         release_ff <= 31'd74565;
         curves_ff  <= 6'd42;
      end else if (csr_write_enable) begin
         case (csr_index)
            ped_pkg::REG_DELAY:   delay_ff   <= csr_data[19:0];
            ped_pkg::REG_HOLD:    hold_ff    <= csr_data[19:0];
            ped_pkg::REG_ATTACK:  attack_ff  <= csr_data;
            ped_pkg::REG_DECAY:   decay_ff   <= csr_data;
            ped_pkg::REG_SUSTAIN: sustain_ff <= csr_data;
            ped_pkg::REG_RELEASE: release_ff <= csr_data;
            ped_pkg::REG_CURVES:  curves_ff  <= csr_data[5:0];
            default: ;
         endcase
      end
   end

   // latched input word
   logic [3:0]        voice_ff;
   logic signed [15:0] gate_ff;
   logic [16:0]       gain_ff;
   logic              blk_ff;
   logic              in_range_ff;
   logic [VW-1:0]     idx_ff;

   // voice state memory, valid bits stand in for the reset value
   logic [WW-1:0]     mem [VOICES];
   logic [VOICES-1:0] vld_ff;
   logic [WW-1:0]     rd_ff;
   logic              rd_vld_ff;
   logic [VW-1:0]     idx_in;

   assign idx_in = VW'(req_voice);

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         voice_ff    <= req_voice;
         gate_ff     <= req_gate_sample;
         gain_ff     <= {1'b0, req_gain_sample} + (req_gain_present ? 17'd0 : 17'd32768);
         blk_ff      <= req_block_end;
         in_range_ff <= (32'(req_voice) < VOICES);
         idx_ff      <= idx_in;
         rd_ff       <= mem[idx_in];
         rd_vld_ff   <= vld_ff[idx_in];
      end
   end

   // working state
   logic [2:0]    ph_ff, ph_in, ph_ld;
   logic [31:0]   lvl_ff, lvl_in;
   logic [CW-1:0] cnt_ff, cnt_in, cnt_ld;
   logic [2:0]    rph;
   logic [31:0]   rlvl;
   logic [CW-1:0] rcnt;

   always_comb begin
      rph  = rd_vld_ff ? rd_ff[WW-1 -: 3] : ped_pkg::PH_IDLE;
      rlvl = rd_vld_ff ? rd_ff[CW +: 32] : 32'd0;
      rcnt = rd_vld_ff ? rd_ff[CW-1:0] : '0;
      ph_ld  = rph;
      cnt_ld = rcnt;
      if (gate_ff > 16'sd16384 && rph == ped_pkg::PH_IDLE) begin
         ph_ld  = ped_pkg::PH_DELAY;
         cnt_ld = CW'(delay_ff);
      end else if (gate_ff < 16'sd16384 && rph != ped_pkg::PH_IDLE) begin
         ph_ld = ped_pkg::PH_RELEASE;
      end
   end

   // phase step and curve
   logic [30:0]        st;
   logic [1:0]         curve;
   logic signed [35:0] st_s, sus_s, lvl_s;
   logic [30:0]        sus;

   always_comb begin
      sus = ped_pkg::cap_one(sustain_ff);
      case (ph_ff)
         ped_pkg::PH_ATTACK: begin
            st = ped_pkg::cap_one(attack_ff);
            curve = curves_ff[1:0];
         end
         ped_pkg::PH_DECAY: begin
            st = ped_pkg::cap_one(decay_ff);
            curve = curves_ff[3:2];
         end
         default: begin
            st = ped_pkg::cap_one(release_ff);
            curve = curves_ff[5:4];
         end
      endcase
      st_s  = $signed({5'd0, st});
      sus_s = $signed({5'd0, sus});
      lvl_s = $signed({4'd0, lvl_ff});
   end

   logic two_mul;
   assign two_mul = (curve == ped_pkg::CURVE_LOG) || (curve == ped_pkg::CURVE_EXP);

   // first and second multiply operands
   logic signed [35:0] a1;
   logic [35:0]        a1_mag;
   logic [31:0]        b2;

   always_comb begin
      case (ph_ff)
         ped_pkg::PH_ATTACK: begin
            if (curve == ped_pkg::CURVE_LOG) a1 = ped_pkg::K_1P4 - lvl_s;
            else a1 = ped_pkg::K_1P1 - lvl_s;
            b2 = (curve == ped_pkg::CURVE_LOG) ? ped_pkg::K_0P9[31:0]
                                              : 32'(ped_pkg::K_2P2 - st_s);
         end
         ped_pkg::PH_DECAY: begin
            if (two_mul) a1 = lvl_s - sus_s + ped_pkg::K_0P1;
            else a1 = lvl_s - sus_s;
            b2 = (curve == ped_pkg::CURVE_LOG) ? 32'(ped_pkg::K_2P2 - st_s)
                                              : ped_pkg::K_0P9[31:0];
         end
         default: begin
            a1 = lvl_s;
            b2 = (curve == ped_pkg::CURVE_LOG) ? 32'(ped_pkg::K_2P2 - st_s)
                                              : ped_pkg::K_0P9[31:0];
         end
      endcase
      a1_mag = a1[35] ? 36'(-a1) : 36'(a1);
   end

   // shared multiplier
   logic [63:0] prod_ff, prod_in, rsum;
   logic [33:0] rmag;
   logic [31:0] mul_a, mul_b;
   logic        neg_ff;
   logic signed [35:0] r1_ff;

   assign rsum = prod_ff + 64'd536870912;
   assign rmag = rsum[63:30];

   always_comb begin
      mul_a = a1_mag[31:0];
      mul_b = {1'b0, st};
      if (cmd.mul2) begin
         mul_a = rmag[31:0];
         mul_b = b2;
      end else if (cmd.mulcv) begin
         mul_a = lvl_ff;
         mul_b = {15'd0, gain_ff};
      end
      prod_in = {32'd0, mul_a} * {32'd0, mul_b};
   end

   always_ff @(posedge clock) begin
      if (cmd.mul1 || cmd.mul2 || cmd.mulcv) prod_ff <= prod_in;
      if (cmd.mul1) neg_ff <= a1[35];
      if (cmd.mul2) r1_ff <= neg_ff ? -$signed({2'd0, rmag}) : $signed({2'd0, rmag});
   end

   // level update
   logic signed [35:0] d2, delta, nl;

   always_comb begin
      d2 = neg_ff ? -$signed({2'd0, rmag}) : $signed({2'd0, rmag});
      delta = two_mul ? d2 : r1_ff;
      nl = lvl_s;
      ph_in = ph_ff;
      cnt_in = cnt_ff;
      case (ph_ff)
         ped_pkg::PH_DELAY, ped_pkg::PH_HOLD: begin
            if (cnt_ff <= CW'(1)) begin
               cnt_in = '0;
               ph_in = (ph_ff == ped_pkg::PH_DELAY) ? ped_pkg::PH_ATTACK : ped_pkg::PH_DECAY;
            end else begin
               cnt_in = cnt_ff - CW'(1);
            end
         end
         ped_pkg::PH_ATTACK: begin
            nl = lvl_s + (two_mul ? delta : st_s);
            if (nl >= ped_pkg::ONE_Q30) begin
               nl = ped_pkg::ONE_Q30;
               cnt_in = CW'(hold_ff);
               ph_in = ped_pkg::PH_HOLD;
            end
         end
         ped_pkg::PH_DECAY: begin
            nl = lvl_s - delta;
            if (nl <= sus_s) begin
               nl = sus_s;
               ph_in = ped_pkg::PH_SUSTAIN;
            end
         end
         ped_pkg::PH_RELEASE: begin
            nl = lvl_s - delta - st_s;
            if (nl < ped_pkg::K_0P01) begin
               nl = '0;
               ph_in = ped_pkg::PH_IDLE;
            end
         end
         default: ;
      endcase
      if (nl < 0) nl = '0;
      if (nl > ped_pkg::LVL_MAX) nl = ped_pkg::LVL_MAX;
      lvl_in = nl[31:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ph_ff  <= ph_ld;
         lvl_ff <= rlvl;
         cnt_ff <= cnt_ld;
      end else if (cmd.upd) begin
         ph_ff  <= ph_in;
         lvl_ff <= lvl_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.upd && in_range_ff) mem[idx_ff] <= {ph_in, lvl_in, cnt_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (cmd.upd && in_range_ff) begin
         vld_ff[idx_ff] <= 1'b1;
      end
   end

   // output register
   logic [43:0] cv_sum;
   logic [26:0] cv_raw;
   logic [25:0] cv_in;
   logic        rsp_valid_ff;

   assign cv_sum = 44'((prod_ff[47:0] + 48'd1048576) >> 21);
   assign cv_raw = cv_sum[26:0];
   assign cv_in  = !in_range_ff ? 26'd0 :
                   (cv_raw > ped_pkg::CV_MAX) ? ped_pkg::CV_MAX[25:0] : cv_raw[25:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_out_voice     <= voice_ff;
         rsp_cv_out        <= cv_in;
         rsp_out_block_end <= blk_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

endmodule

// ===== design/poly_dahdsr_envelope_top.sv =====
// top level of the polyphonic dahdsr envelope generator
// polyphonic delay-attack-hold-decay-sustain-release envelope: each accepted word carries
// one sample for one voice; the voice's phase, q2.30 level and countdown are read from a
// small state memory, stepped once and written back, and one result word with the level
// times gain (q2.24, rounded, saturated to 2.0) is returned. from accept to result the
// sequencer steps through memory read, two passes through one shared 32x32 multiplier
// for the curve, the level update, one multiplier pass for the gain and the output load,
// which waits while a stalled result still holds the output register.
// the next word is taken once the sequencer is back in idle, even while the previous result
// still waits on the output register. no clearing pass is needed after reset.
module poly_dahdsr_envelope_top #(
   parameter int VOICES      = ped_pkg::VOICES_DEFAULT,
   parameter int COUNT_WIDTH = ped_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   // configuration writes
   input  logic                csr_write_enable,
   input  logic [2:0]          csr_index,
   input  logic [30:0]         csr_data,
   // input words
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [3:0]          req_voice,
   input  logic signed [15:0]  req_gate_sample,
   input  logic [15:0]         req_gain_sample,
   input  logic                req_gain_present,
   input  logic                req_block_end,
   // result words
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [3:0]          rsp_out_voice,
   output logic [25:0]         rsp_cv_out,
   output logic                rsp_out_block_end
);

   ped_pkg::cmd_type    cmd;
   ped_pkg::status_type status;

   // sequencer
   ped_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // state memory, multiplier and output register
   ped_datapath #(
      .VOICES      (VOICES),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_voice         (req_voice),
      .req_gate_sample   (req_gate_sample),
      .req_gain_sample   (req_gain_sample),
      .req_gain_present  (req_gain_present),
      .req_block_end     (req_block_end),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_voice     (rsp_out_voice),
      .rsp_cv_out        (rsp_cv_out),
      .rsp_out_block_end (rsp_out_block_end)
   );

`ifndef SYNTHESIS
   // one sequencer step at a time
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.accept, cmd.load, cmd.mul1, cmd.mul2, cmd.upd, cmd.mulcv, cmd.out_load}))
      else $error("more than one sequencer command");
   // an accepted word blocks the input until its result is loaded
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken while busy");
   // never overwrite a stalled result
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(rsp_valid && rsp_stall))
      else $error("result overwritten while stalled");
`endif

endmodule

// ===== test/poly_dahdsr_envelope_top_tb.sv =====
// testbench for the polyphonic dahdsr envelope generator
`timescale 1ns / 1ps

module poly_dahdsr_envelope_top_tb;

   localparam int NUM_VOICES = 16;
   localparam int STALL_LIMIT = 5000;   // cycles with no word moving before giving up
   localparam int DRAIN_CYCLES = 12;
   localparam int PHASES = 8;
   localparam int WORDS_PER_PHASE = 240;
   localparam longint UNIT = 64'sd1073741824;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [2:0] csr_index = '0;
   logic [30:0] csr_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [3:0] req_voice = '0;
   logic signed [15:0] req_gate_sample = '0;
   logic [15:0] req_gain_sample = '0;
   logic req_gain_present = 1'b0;
   logic req_block_end = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [3:0] rsp_out_voice;
   logic [25:0] rsp_cv_out;
   logic rsp_out_block_end;

   poly_dahdsr_envelope_top dut (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index), .csr_data(csr_data),
      .req_valid(req_valid), .req_stall(req_stall), .req_voice(req_voice),
      .req_gate_sample(req_gate_sample), .req_gain_sample(req_gain_sample),
      .req_gain_present(req_gain_present), .req_block_end(req_block_end),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_out_voice(rsp_out_voice),
      .rsp_cv_out(rsp_cv_out), .rsp_out_block_end(rsp_out_block_end)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // expected result words, oldest first
   typedef struct {
      logic [3:0] voice;
      logic [25:0] cv;
      logic block_end;
   } env_word_type;
   env_word_type pending_env[$];

   // predictor copy of the settings and the voice memory
   logic [19:0] delay_len, hold_len;
   logic [30:0] attack_rate, decay_rate, sustain_target, release_rate;
   logic [5:0] curve_sel;
   logic [2:0] env_phase[NUM_VOICES];
   longint env_level[NUM_VOICES];
   logic [19:0] env_count[NUM_VOICES];

   int mismatches = 0;
   int words_in = 0;
   int words_out = 0;
   int quiet_cycles = 0;
   bit idle_on = 1'b1;
   bit hold_request = 1'b0;
   int hold_left = 0;
   bit gate_high[NUM_VOICES];

   // q2.30 product, rounded to nearest with halves away from zero
   function automatic longint q30_mul(longint a, longint b);
      bit neg;
      longint unsigned ua, ub, r;
      neg = (a < 0) != (b < 0);
      ua = (a < 0) ? longint'(-a) : a;
      ub = (b < 0) ? longint'(-b) : b;
      r = (ua * ub + (64'd1 << 29)) >> 30;
      return neg ? -longint'(r) : longint'(r);
   endfunction

   // rates and sustain above 1.0 act as 1.0
   function automatic longint clip_unit(logic [30:0] v);
      return (v > 31'd1073741824) ? UNIT : longint'(v);
   endfunction

   function automatic void settings_reset();
      delay_len = 20'd5;
      hold_len = 20'd5;
      attack_rate = 31'd44739;
      decay_rate = 31'd74565;
      sustain_target = 31'd536870912;
      release_rate = 31'd74565;
      curve_sel = 6'd42;
      for (int i = 0; i < NUM_VOICES; i++) begin
         env_phase[i] = ped_pkg::PH_IDLE;
         env_level[i] = 0;
         env_count[i] = '0;
         gate_high[i] = 1'b0;
      end
   endfunction

   function automatic void settings_write(logic [2:0] idx, logic [30:0] data);
      case (idx)
         ped_pkg::REG_DELAY: delay_len = data[19:0];
         ped_pkg::REG_HOLD: hold_len = data[19:0];
         ped_pkg::REG_ATTACK: attack_rate = data;
         ped_pkg::REG_DECAY: decay_rate = data;
         ped_pkg::REG_SUSTAIN: sustain_target = data;
         ped_pkg::REG_RELEASE: release_rate = data;
         ped_pkg::REG_CURVES: curve_sel = data[5:0];
         default: ;
      endcase
   endfunction

   // one envelope step for one voice; returns level times gain in q2.24
   function automatic logic [25:0] envelope_step(logic [3:0] v, logic signed [15:0] gate,
                                                 logic [15:0] gain_in, logic present);
      longint lvl, sus, st, gain;
      longint unsigned cv;
      logic [1:0] curve;
      gain = longint'(gain_in) + (present ? 0 : 32768);
      lvl = env_level[v];
      sus = clip_unit(sustain_target);
      if (gate > 16384 && env_phase[v] == ped_pkg::PH_IDLE) begin
         env_phase[v] = ped_pkg::PH_DELAY;
         env_count[v] = delay_len;
      end else if (gate < 16384 && env_phase[v] != ped_pkg::PH_IDLE) begin
         env_phase[v] = ped_pkg::PH_RELEASE;
      end
      case (env_phase[v])
         ped_pkg::PH_DELAY: begin
            if (env_count[v] <= 1) begin
               env_count[v] = '0;
               env_phase[v] = ped_pkg::PH_ATTACK;
            end else env_count[v] = env_count[v] - 20'd1;
         end
         ped_pkg::PH_ATTACK: begin
            st = clip_unit(attack_rate);
            curve = curve_sel[1:0];
            if (curve == ped_pkg::CURVE_LOG)
               lvl += q30_mul(q30_mul(ped_pkg::K_1P4 - lvl, st), ped_pkg::K_0P9);
            else if (curve == ped_pkg::CURVE_EXP)
               lvl += q30_mul(q30_mul(ped_pkg::K_1P1 - lvl, st), ped_pkg::K_2P2 - st);
            else lvl += st;
            if (lvl >= UNIT) begin
               lvl = UNIT;
               env_count[v] = hold_len;
               env_phase[v] = ped_pkg::PH_HOLD;
            end
         end
         ped_pkg::PH_HOLD: begin
            if (env_count[v] <= 1) begin
               env_count[v] = '0;
               env_phase[v] = ped_pkg::PH_DECAY;
            end else env_count[v] = env_count[v] - 20'd1;
         end
         ped_pkg::PH_DECAY: begin
            st = clip_unit(decay_rate);
            curve = curve_sel[3:2];
            if (curve == ped_pkg::CURVE_LOG)
               lvl -= q30_mul(q30_mul(lvl - sus + ped_pkg::K_0P1, st), ped_pkg::K_2P2 - st);
            else if (curve == ped_pkg::CURVE_EXP)
               lvl -= q30_mul(q30_mul(lvl - sus + ped_pkg::K_0P1, st), ped_pkg::K_0P9);
            else lvl -= q30_mul(st, lvl - sus);
            if (lvl <= sus) begin
               lvl = sus;
               env_phase[v] = ped_pkg::PH_SUSTAIN;
            end
         end
         ped_pkg::PH_RELEASE: begin
            st = clip_unit(release_rate);
            curve = curve_sel[5:4];
            if (curve == ped_pkg::CURVE_LOG)
               lvl -= q30_mul(q30_mul(lvl, st), ped_pkg::K_2P2 - st);
            else if (curve == ped_pkg::CURVE_EXP)
               lvl -= q30_mul(q30_mul(lvl, st), ped_pkg::K_0P9);
            else lvl -= q30_mul(st, lvl);
            lvl -= st;
            if (lvl < ped_pkg::K_0P01) begin
               lvl = 0;
               env_phase[v] = ped_pkg::PH_IDLE;
            end
         end
         default: ;
      endcase
      if (lvl < 0) lvl = 0;
      if (lvl > ped_pkg::LVL_MAX) lvl = ped_pkg::LVL_MAX;
      env_level[v] = lvl;
      cv = (longint'(lvl) * gain + (64'd1 << 20)) >> 21;
      if (cv > ped_pkg::CV_MAX) cv = ped_pkg::CV_MAX;
      return cv[25:0];
   endfunction

   // offer one word, wait for it to be taken, then record what must come back
   task automatic send_word(logic [3:0] v, logic signed [15:0] gate, logic [15:0] gain,
                            logic present, logic be, bit known, logic [25:0] known_cv);
      env_word_type w;
      logic [25:0] cv;
      if (idle_on && $urandom_range(99) < 14) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat ($urandom_range(2)) @(negedge clock);
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_voice = v;
      req_gate_sample = gate;
      req_gain_sample = gain;
      req_gain_present = present;
      req_block_end = be;
      do @(posedge clock); while (req_stall);
      cv = envelope_step(v, gate, gain, present);
      w.voice = v;
      w.cv = known ? known_cv : cv;
      w.block_end = be;
      pending_env.push_back(w);
      words_in++;
   endtask

   // drop valid and let the block empty out and settle; write_reg writes one register
   task automatic drain_input();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_env.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [30:0] data);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index = idx;
      csr_data = data;
      settings_write(idx, data);
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   // receiver: random stall, plus one long hold-off on request
   always @(negedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left = 80;
      end
      if (hold_left > 0) begin
         rsp_stall = 1'b1;
         hold_left--;
      end else rsp_stall = idle_on && ($urandom_range(99) < 14);
   end

   // result checker and watchdog
   always @(posedge clock) begin
      env_word_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         words_out++;
         if (pending_env.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word: voice %0d cv %0d",
                                           rsp_out_voice, rsp_cv_out);
         end else begin
            w = pending_env.pop_front();
            if (w.voice !== rsp_out_voice || w.cv !== rsp_cv_out ||
                w.block_end !== rsp_out_block_end) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch word %0d: expected voice %0d cv %0d end %0b, got %0d %0d %0b",
                           words_out, w.voice, w.cv, w.block_end,
                           rsp_out_voice, rsp_cv_out, rsp_out_block_end);
            end
         end
      end
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // directed words: voice, gate, gain, gain present, block end, known, known cv
   typedef struct {
      logic [3:0] voice;
      logic signed [15:0] gate;
      logic [15:0] gain;
      logic present;
      logic be;
      bit known;
      logic [25:0] cv;
   } stim_row_type;

   stim_row_type directed[] = '{
      '{4'd0, -16'sd32768, 16'd0, 1'b0, 1'b0, 1'b1, 26'd0},     // release request on idle voice
      '{4'd0, 16'sd16384, 16'hFFFF, 1'b1, 1'b1, 1'b1, 26'd0},   // gate exactly half, no trigger
      '{4'd0, 16'sd32767, 16'd32768, 1'b1, 1'b0, 1'b1, 26'd0},  // trigger, delay starts
      '{4'd0, 16'sd20000, 16'd32768, 1'b1, 1'b0, 1'b1, 26'd0},
      '{4'd0, 16'sd16385, 16'd32768, 1'b1, 1'b1, 1'b1, 26'd0},
      '{4'd0, 16'sd32767, 16'd32768, 1'b1, 1'b0, 1'b1, 26'd0},
      '{4'd0, 16'sd32767, 16'd32768, 1'b1, 1'b0, 1'b1, 26'd0},  // delay ends here
      '{4'd0, 16'sd32767, 16'd32768, 1'b1, 1'b0, 1'b0, 26'd0},  // attack
      '{4'd0, 16'sd32767, 16'hFFFF, 1'b0, 1'b0, 1'b0, 26'd0},   // largest gain
      '{4'd15, 16'sd32767, 16'd0, 1'b0, 1'b1, 1'b1, 26'd0},     // top voice triggers
      '{4'd0, 16'sd16384, 16'd32768, 1'b1, 1'b0, 1'b0, 26'd0},  // half gate mid attack
      '{4'd0, 16'sd16383, 16'd12345, 1'b1, 1'b0, 1'b0, 26'd0},  // into release
      '{4'd0, 16'sd32767, 16'd32768, 1'b1, 1'b0, 1'b0, 26'd0},  // gate high in release
      '{4'd15, -16'sd1, 16'd32768, 1'b1, 1'b0, 1'b1, 26'd0},    // release straight from delay
      '{4'd7, 16'sd32767, 16'hFFFF, 1'b0, 1'b1, 1'b1, 26'd0},
      '{4'd7, -16'sd32768, 16'hAAAA, 1'b1, 1'b0, 1'b1, 26'd0}
   };

   initial begin
      logic [3:0] v;
      logic signed [15:0] gate;
      int r;
      settings_reset();
      repeat (7) @(negedge clock);
      reset = 1'b0;

      foreach (directed[i])
         send_word(directed[i].voice, directed[i].gate, directed[i].gain, directed[i].present,
                   directed[i].be, directed[i].known, directed[i].cv);

      for (int ph = 0; ph < PHASES; ph++) begin
         drain_input();
         // settings for this phase: defaults, all zero, all ones, then fast random ones
         case (ph)
            0: ;
            1: for (int k = int'(ped_pkg::REG_DELAY); k <= int'(ped_pkg::REG_CURVES); k++)
                  write_reg(k[2:0], '0);
            2: for (int k = int'(ped_pkg::REG_DELAY); k <= int'(ped_pkg::REG_CURVES); k++)
                  write_reg(k[2:0], '1);
            default: begin
               write_reg(ped_pkg::REG_DELAY, 31'($urandom_range(6)));
               write_reg(ped_pkg::REG_HOLD, 31'($urandom_range(6)));
               write_reg(ped_pkg::REG_ATTACK,
                         ph == 7 ? 31'h7FFFFFFF : 31'($urandom_range(1 << 28, 1 << 21)));
               write_reg(ped_pkg::REG_DECAY, 31'($urandom_range(1 << 28, 1 << 21)));
               write_reg(ped_pkg::REG_SUSTAIN,
                         ph == 7 ? 31'h40000000 : 31'($urandom_range(1 << 30)));
               write_reg(ped_pkg::REG_RELEASE, 31'($urandom_range(1 << 28, 1 << 21)));
               write_reg(ped_pkg::REG_CURVES, ph == 3 ? 31'd63 : 31'($urandom_range(63)));
            end
         endcase
         idle_on = (ph != 4);   // one phase runs with no idling on either side
         for (int n = 0; n < WORDS_PER_PHASE; n++) begin
            if (ph == 5 && n == 40) hold_request = 1'b1;
            v = ($urandom_range(99) < 80) ? 4'($urandom_range(3)) : 4'($urandom_range(15));
            if ($urandom_range(99) < (gate_high[v] ? 3 : 10)) gate_high[v] = !gate_high[v];
            r = $urandom_range(99);
            if (r < 5) gate = 16'sd16384;
            else if (r < 8) gate = 16'($urandom);
            else if (gate_high[v]) gate = 16'($urandom_range(32767, 16385));
            else gate = 16'(int'($urandom_range(49151)) - 32768);
            send_word(v, gate, 16'($urandom), 1'($urandom), 1'($urandom), 1'b0, '0);
         end
      end

      @(negedge clock);
      req_valid = 1'b0;
      while (pending_env.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("run covered %0d words over %0d register settings incl. all-zero and all-one",
               words_in, PHASES);
      $display("results checked: %0d, mismatches: %0d", words_out, mismatches);
      if (mismatches == 0 && pending_env.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
